// ----- design/gle_pkg.sv -----
// gle_pkg: shared types and fixed constants of the gif lzw encoder
// no dependencies; imported by the encoder top level and its output queue
`timescale 1ns / 1ps

package gle_pkg;

   localparam int CODE_BITS  = 12;
   localparam int WIDTH_BITS = 4;
   localparam int EPOCH_BITS = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_BITS  = 3;

   typedef enum logic [1:0] {
      ST_CLR,
      ST_IDLE,
      ST_START,
      ST_CMP
   } state_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]  code;
      logic [WIDTH_BITS-1:0] width;
      logic                  last;
   } code_entry_type;

   typedef struct packed {
      logic                                 load;
      logic [QCNT_BITS-1:0]                 count;
      code_entry_type [QUEUE_DEPTH-1:0]     ents;
   } queue_load_type;

endpackage

// ----- design/gle_dict_ram.sv -----
// gle_dict_ram: single port synchronous dictionary memory with registered read data
// generic storage, no package dependency
`timescale 1ns / 1ps

module gle_dict_ram #(
   parameter int ADDR_BITS = 13,
   parameter int DATA_BITS = 40
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wdata,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [(1<<ADDR_BITS)];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end

endmodule

// ----- design/gle_out_queue.sv -----
// gle_out_queue: holds up to four codes of one pixel and drives them out one beat each
// depends on gle_pkg for the entry and load types
`timescale 1ns / 1ps

module gle_out_queue
   import gle_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_load_type q_load,
   output logic           q_empty,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [15:0]    rsp_tdata,  // code[11:0], code_width[15:12]
   output logic           rsp_tlast   // last_code
);

   code_entry_type [QUEUE_DEPTH-1:0] ent_ff;
   logic [QCNT_BITS-1:0]             cnt_ff;
   logic [1:0]                       idx_ff;
   logic                             ovalid_ff;
   code_entry_type                   out_ff;
   logic                             take;

   assign take    = (!ovalid_ff || rsp_tready) && (cnt_ff != '0);
   assign q_empty = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         idx_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (q_load.load) begin
            ent_ff <= q_load.ents;
            cnt_ff <= q_load.count;
            idx_ff <= '0;
         end else if (take) begin
            cnt_ff <= cnt_ff - QCNT_BITS'(1);
            idx_ff <= idx_ff + 2'd1;
         end
         if (take) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= ent_ff[idx_ff];
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {out_ff.width, out_ff.code};
   assign rsp_tlast  = out_ff.last;

endmodule

// ----- design/gif_lzw_encoder.sv -----
// gif_lzw_encoder: a pixel beat passes accept and then compare (an image start: accept and
// start), with one more compare for each extra hash probe; the codes of one pixel leave
// one beat a cycle while rsp_tready is high, and the next pixel is taken once they have
// moved to the output register; synchronous reset runs a clearing pass over all
// HASH_DEPTH dictionary entries, repeated after every 255 dictionary restarts when the
// epoch mark wraps; no pixel is taken during the pass
`timescale 1ns / 1ps

module gif_lzw_encoder
   import gle_pkg::*;
#(
   parameter int MAX_CODE_BITS = 12,
   parameter int HASH_DEPTH    = 8192,
   parameter int PIXEL_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   // pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel_index[7:0]
   input  logic        req_tlast,   // last_pixel
   // code stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code[11:0], code_width[15:12]
   output logic        rsp_tlast,   // last_code
   // minimum code size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // min_size[3:0]
);

   localparam int MW    = MAX_CODE_BITS;
   localparam int NW    = MAX_CODE_BITS + 1;
   localparam int AW    = $clog2(HASH_DEPTH);
   localparam int KW    = MAX_CODE_BITS + PIXEL_BITS;
   localparam int DW    = EPOCH_BITS + KW + MW;
   localparam int HW0   = (PIXEL_BITS + 5 > MW) ? PIXEL_BITS + 5 : MW;
   localparam int HASHW = (HW0 > AW) ? HW0 : AW;
   localparam int RST_M = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;

   // encoder state
   state_type              state_ff, state_in;
   logic [3:0]             min_ff;
   logic [MW-1:0]          prefix_ff, prefix_in;
   logic [NW-1:0]          nfc_ff, nfc_in;
   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic                   started_ff, started_in;
   logic [EPOCH_BITS-1:0]  epoch_ff;
   logic [AW-1:0]          slot_ff;
   logic [AW-1:0]          clr_ff;
   logic [PIXEL_BITS-1:0]  pix_ff;
   logic                   last_ff;

   // effective minimum code size and derived codes
   logic [3:0]             m;
   logic [MW-1:0]          cc;
   logic [PIXEL_BITS-1:0]  pix_in;
   logic [HASHW-1:0]       hash_in;
   logic                   accept;

   // dictionary port
   logic                   mem_en, mem_we;
   logic [AW-1:0]          mem_addr;
   logic [DW-1:0]          mem_wdata, mem_rdata;
   logic [EPOCH_BITS-1:0]  r_tag;
   logic [KW-1:0]          r_key, cmp_key;
   logic [MW-1:0]          r_code;
   logic                   r_live, hit, probe, decide;

   // decision results
   logic                   restart, insert;
   queue_load_type         q_load;
   logic                   q_empty;

   always_comb begin
      m = min_ff;
      if (m < 4'd2) m = 4'd2;
      if (m > 4'(PIXEL_BITS)) m = 4'(PIXEL_BITS);
   end

   assign cc      = MW'(1) << m;
   assign pix_in  = req_tdata[PIXEL_BITS-1:0] & PIXEL_BITS'(cc - MW'(1));
   // hash slot: (pixel << 5) xor prefix, truncated to the table address width
   assign hash_in = HASHW'({pix_in, 5'b0}) ^ HASHW'(prefix_ff);
   assign accept  = req_tvalid && req_tready;

   assign {r_tag, r_key, r_code} = mem_rdata;
   assign cmp_key = {prefix_ff, pix_ff};
   // an entry is live only when tagged with the current epoch
   assign r_live  = (r_tag == epoch_ff);
   assign hit     = r_live && (r_key == cmp_key);
   assign probe   = r_live && !hit;
   assign decide  = (state_ff == ST_START) || ((state_ff == ST_CMP) && !probe);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = started_ff ? ST_CMP : ST_START;
         end
         ST_START, ST_CMP: begin
            if (decide) begin
               state_in = (restart && (epoch_ff == '1)) ? ST_CLR : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory port
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && q_empty;
      csr_ready  = 1'b1;
      mem_en     = 1'b0;
      mem_we     = 1'b0;
      mem_addr   = slot_ff;
      mem_wdata  = {epoch_ff, cmp_key, nfc_ff[MW-1:0]};
      case (state_ff)
         ST_CLR: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            mem_en   = accept && started_ff;
            mem_addr = hash_in[AW-1:0];
         end
         ST_CMP: begin
            if (probe) begin
               mem_en   = 1'b1;
               mem_addr = slot_ff + AW'(1);
            end else if (insert) begin
               mem_en = 1'b1;
               mem_we = 1'b1;
            end
         end
         default: begin
            mem_en = 1'b0;
         end
      endcase
   end

   // code emission, table growth and flush for one pixel
   always_comb begin
      logic [QCNT_BITS-1:0]  n;
      logic [WIDTH_BITS-1:0] ew;
      n          = '0;
      ew         = '0;
      prefix_in  = prefix_ff;
      nfc_in     = nfc_ff;
      width_in   = width_ff;
      started_in = started_ff;
      restart    = 1'b0;
      insert     = 1'b0;
      q_load     = '0;
      if (state_ff == ST_START) begin
         // image start: clear code and a fresh table
         restart    = 1'b1;
         nfc_in     = NW'(cc) + NW'(2);
         width_in   = WIDTH_BITS'(m + 4'd1);
         q_load.ents[0] = '{code: CODE_BITS'(cc), width: width_in, last: 1'b0};
         n          = QCNT_BITS'(1);
         prefix_in  = pix_ff;
         started_in = 1'b1;
      end else if (hit) begin
         prefix_in = r_code;
      end else begin
         // miss: emit prefix and add the pair
         q_load.ents[0] = '{code: CODE_BITS'(prefix_ff), width: width_ff, last: 1'b0};
         n      = QCNT_BITS'(1);
         insert = 1'b1;
         if ((nfc_ff == (NW'(1) << width_ff)) && (width_ff < WIDTH_BITS'(MAX_CODE_BITS))) begin
            width_in = width_ff + WIDTH_BITS'(1);
         end
         nfc_in = nfc_ff + NW'(1);
         if (nfc_in[NW-1]) begin
            // table full: clear code at the current width
            q_load.ents[1] = '{code: CODE_BITS'(cc), width: width_in, last: 1'b0};
            n        = QCNT_BITS'(2);
            restart  = 1'b1;
            nfc_in   = NW'(cc) + NW'(2);
            width_in = WIDTH_BITS'(m + 4'd1);
         end
         prefix_in = pix_ff;
      end
      if (last_ff) begin
         // flush prefix, then end code, one bit wider when the decoder's entry fills the width
         ew = width_in;
         if ((nfc_in != NW'(cc) + NW'(2)) && (nfc_in + NW'(1) == (NW'(1) << width_in))
             && (width_in < WIDTH_BITS'(MAX_CODE_BITS))) begin
            ew = width_in + WIDTH_BITS'(1);
         end
         q_load.ents[n[1:0]] = '{code: CODE_BITS'(prefix_in), width: width_in, last: 1'b0};
         q_load.ents[n[1:0] + 2'd1] = '{code: CODE_BITS'(cc) + CODE_BITS'(1), width: ew,
                                        last: 1'b1};
         n          = n + QCNT_BITS'(2);
         started_in = 1'b0;
      end
      q_load.count = n;
      q_load.load  = decide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         min_ff     <= 4'd8;
         prefix_ff  <= '0;
         nfc_ff     <= (NW'(1) << RST_M) + NW'(2);
         width_ff   <= WIDTH_BITS'(RST_M + 1);
         started_ff <= 1'b0;
         epoch_ff   <= EPOCH_BITS'(1);
         clr_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLR) begin
            clr_ff <= clr_ff + AW'(1);
            if (clr_ff == '1) epoch_ff <= EPOCH_BITS'(1);
         end
         if (decide) begin
            prefix_ff  <= prefix_in;
            nfc_ff     <= nfc_in;
            width_ff   <= width_in;
            started_ff <= started_in;
            // a restart drops every entry by moving to a new epoch (at the top epoch, by a clearing pass)
            if (restart && (epoch_ff != '1)) epoch_ff <= epoch_ff + EPOCH_BITS'(1);
         end
         if (csr_valid && csr_ready) begin
            min_ff     <= csr_data;
            started_ff <= 1'b0;
            prefix_ff  <= '0;
         end
      end
   end

   // pixel and probe registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= pix_in;
         last_ff <= req_tlast;
         slot_ff <= hash_in[AW-1:0];
      end else if ((state_ff == ST_CMP) && probe) begin
         slot_ff <= slot_ff + AW'(1);
      end
   end

   gle_dict_ram #(
      .ADDR_BITS (AW),
      .DATA_BITS (DW)
   ) u_dict (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   gle_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_load     (q_load),
      .q_empty    (q_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("pixel taken while previous one in work");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CMP || state_ff == ST_CLR))
      else $error("dictionary write outside compare or clear");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> !started_ff)
      else $error("register write did not end the image");
   a_nfc_bound: assert property (@(posedge clock) disable iff (reset)
      !nfc_ff[NW-1])
      else $error("next free code reached table size");
`endif

endmodule
